// ===== sv/rri_pkg.sv =====
// Shared constants and types for the ray and rectangle intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rri_pkg;

    localparam int CB       = 20;
    localparam int TB       = 32;
    localparam int TFRAC    = 16;
    localparam int POS_FRAC = CB / 2;
    localparam int DIR_FRAC = CB - 2;
    localparam int TSHIFT   = TFRAC + DIR_FRAC - POS_FRAC;
    localparam int LOW_W    = TB - TSHIFT;

    localparam int DIFF_W = CB + 1;
    localparam int NP_W   = 2 * CB + 1;
    localparam int DP_W   = 2 * CB;
    localparam int NUM_W  = NP_W + 2;
    localparam int DEN_W  = DP_W + 2;
    localparam int MP_W   = TB + CB;
    localparam int P_W    = MP_W - TSHIFT;
    localparam int V_W    = P_W + 2;
    localparam int Q_W    = CB + 4;
    localparam int XP_W   = CB + Q_W;
    localparam int XD_W   = XP_W + 1;
    localparam int M_W    = XD_W - DIR_FRAC;
    localparam int SQ_W   = 2 * M_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = SUM_W + 2;
    localparam int WH_W   = 2 * CB;

    localparam int LATENCY = TB + 10;

    localparam logic [TB-1:0] T_CAP = TB'(1) << (TB - 1);
    localparam logic signed [V_W-1:0] Q_LIM = (V_W'(1) << (CB + 3)) - V_W'(1);

    typedef enum logic [2:0] {
        CFG_CENTRE = 3'd0,
        CFG_NORMAL = 3'd1,
        CFG_AXIS_U = 3'd2,
        CFG_AXIS_V = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                      parallel;
        logic                      neg;
        logic [2:0][DIFF_W-1:0]    rel;
        logic [2:0][CB-1:0]        dir;
    } side_t;

    typedef struct packed {
        logic               valid;
        logic               ovf;
        logic [DEN_W-1:0]   div;
        logic [DEN_W-1:0]   rem;
        logic [TB-1:0]      quo;
        logic [LOW_W-1:0]   low;
        side_t              side;
    } div_stage_t;

endpackage
`default_nettype wire

// ===== sv/rri_front.sv =====
// Front stages: plane dot products, their magnitudes and the divider set-up.
`timescale 1ns / 1ps
`default_nettype none
module rri_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [2:0][rri_pkg::CB-1:0]   origin,
    input  wire logic [2:0][rri_pkg::CB-1:0]   dir,
    input  wire logic [3*rri_pkg::CB-1:0]      centre,
    input  wire logic [3*rri_pkg::CB-1:0]      normal,
    output rri_pkg::div_stage_t                stage_out
);

    logic signed [rri_pkg::DIFF_W-1:0] co [3];
    logic signed [rri_pkg::DIFF_W-1:0] oc [3];
    logic signed [rri_pkg::CB-1:0]     nv [3];

    logic                               v1_reg;
    logic signed [rri_pkg::NP_W-1:0]    pn_reg [3];
    logic signed [rri_pkg::DP_W-1:0]    pd_reg [3];
    logic [2:0][rri_pkg::DIFF_W-1:0]    rel1_reg;
    logic [2:0][rri_pkg::CB-1:0]        dir1_reg;

    logic                               v2_reg;
    logic signed [rri_pkg::NUM_W-1:0]   num_reg;
    logic signed [rri_pkg::DEN_W-1:0]   den_reg;
    logic [2:0][rri_pkg::DIFF_W-1:0]    rel2_reg;
    logic [2:0][rri_pkg::CB-1:0]        dir2_reg;

    logic [rri_pkg::NUM_W-1:0]          a_mag;
    logic [rri_pkg::DEN_W-1:0]          b_mag;
    rri_pkg::div_stage_t                st_next;
    rri_pkg::div_stage_t                st_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = $signed(normal[i*rri_pkg::CB +: rri_pkg::CB]);
            co[i] = rri_pkg::DIFF_W'($signed(centre[i*rri_pkg::CB +: rri_pkg::CB]))
                  - rri_pkg::DIFF_W'($signed(origin[i]));
            oc[i] = -co[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pn_reg[i] <= rri_pkg::NP_W'(nv[i]) * rri_pkg::NP_W'(co[i]);
            pd_reg[i] <= rri_pkg::DP_W'(nv[i]) * rri_pkg::DP_W'($signed(dir[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            rel1_reg[i] <= oc[i];
        end
        dir1_reg <= dir;
        num_reg  <= rri_pkg::NUM_W'(pn_reg[0]) + rri_pkg::NUM_W'(pn_reg[1])
                  + rri_pkg::NUM_W'(pn_reg[2]);
        den_reg  <= rri_pkg::DEN_W'(pd_reg[0]) + rri_pkg::DEN_W'(pd_reg[1])
                  + rri_pkg::DEN_W'(pd_reg[2]);
        rel2_reg <= rel1_reg;
        dir2_reg <= dir1_reg;
    end

    always_comb
    begin
        a_mag = num_reg[rri_pkg::NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
        b_mag = den_reg[rri_pkg::DEN_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
        st_next.valid = v2_reg;
        st_next.ovf   = (rri_pkg::DEN_W + rri_pkg::LOW_W)'(a_mag)
                      >= {b_mag, rri_pkg::LOW_W'(0)};
        st_next.div   = b_mag;
        st_next.rem   = rri_pkg::DEN_W'(a_mag >> rri_pkg::LOW_W);
        st_next.quo   = '0;
        st_next.low   = a_mag[rri_pkg::LOW_W-1:0];
        st_next.side.parallel = (den_reg == '0);
        st_next.side.neg      = num_reg[rri_pkg::NUM_W-1] ^ den_reg[rri_pkg::DEN_W-1];
        st_next.side.rel      = rel2_reg;
        st_next.side.dir      = dir2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign stage_out = st_reg;

endmodule
`default_nettype wire

// ===== sv/rri_divide.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module rri_divide (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rri_pkg::div_stage_t stage_in,
    output rri_pkg::div_stage_t stage_out
);

    rri_pkg::div_stage_t st [rri_pkg::TB+1];

    assign st[0] = stage_in;

    for (genvar k = 0; k < rri_pkg::TB; k++)
    begin : g_step
        localparam int J  = rri_pkg::TB - 1 - k;
        localparam int LB = (J >= rri_pkg::TSHIFT) ? J - rri_pkg::TSHIFT : 0;
        logic                       dbit;
        logic [rri_pkg::DEN_W:0]    r2;
        logic                       ge;
        rri_pkg::div_stage_t        st_next;
        rri_pkg::div_stage_t        st_reg;

        always_comb
        begin
            if (J >= rri_pkg::TSHIFT)
            begin
                dbit = st[k].low[LB];
            end
            else
            begin
                dbit = 1'b0;
            end
            r2 = {st[k].rem, dbit};
            ge = r2 >= {1'b0, st[k].div};
            st_next     = st[k];
            st_next.rem = ge ? rri_pkg::DEN_W'(r2 - {1'b0, st[k].div})
                             : rri_pkg::DEN_W'(r2);
            st_next.quo = {st[k].quo[rri_pkg::TB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg <= '0;
            end
            else
            begin
                st_reg <= st_next;
            end
        end

        assign st[k+1] = st_reg;
    end

    assign stage_out = st[rri_pkg::TB];

endmodule
`default_nettype wire

// ===== sv/rri_hit.sv =====
// Back stages: saturate t, form the hit point and test it against both axes.
`timescale 1ns / 1ps
`default_nettype none
module rri_hit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rri_pkg::div_stage_t        stage_in,
    input  wire logic [3*rri_pkg::CB-1:0]   axis_u,
    input  wire logic [3*rri_pkg::CB-1:0]   axis_v,
    input  wire logic [rri_pkg::CB-1:0]     width,
    input  wire logic [rri_pkg::CB-1:0]     height,
    output logic                            done,
    output logic                            hit,
    output logic signed [rri_pkg::TB-1:0]   distance,
    output logic                            parallel
);

    logic [rri_pkg::TB-1:0]   quo_sat;
    logic [rri_pkg::TB-1:0]   tm_next;

    logic [5:0]                         vld_reg;
    logic [5:0]                         par_reg;
    logic [rri_pkg::TB-1:0]             t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [rri_pkg::TB-1:0]             tm_reg;
    logic                               tneg_reg;
    logic [2:0][rri_pkg::DIFF_W-1:0]    rel0_reg, rel1_reg;
    logic [2:0][rri_pkg::CB-1:0]        dir0_reg;

    logic [rri_pkg::MP_W-1:0]           prod_reg [3];
    logic [2:0]                         sub_reg;
    logic signed [rri_pkg::Q_W-1:0]     q_reg [3];
    logic signed [rri_pkg::XP_W-1:0]    xp_reg [2][6];
    logic [rri_pkg::M_W-1:0]            m_reg [2][3];
    logic [rri_pkg::SQ_W-1:0]           sq_reg [2][3];
    logic [rri_pkg::WH_W-1:0]           hh_reg, ww_reg;

    logic signed [rri_pkg::V_W-1:0]     val [3];
    logic signed [rri_pkg::CB-1:0]      ax [2][3];
    logic signed [rri_pkg::XD_W-1:0]    xd [2][3];
    logic [rri_pkg::XD_W-1:0]           xm [2][3];
    logic [rri_pkg::CMP_W-1:0]          sum4 [2];
    logic                               hit_next;

    always_comb
    begin
        quo_sat = (stage_in.ovf || stage_in.quo > rri_pkg::T_CAP) ? rri_pkg::T_CAP
                                                                  : stage_in.quo;
        if (stage_in.side.neg)
        begin
            tm_next = quo_sat;
        end
        else
        begin
            tm_next = (quo_sat == rri_pkg::T_CAP) ? rri_pkg::T_CAP - rri_pkg::TB'(1)
                                                  : quo_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], stage_in.valid};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ax[0][i] = $signed(axis_u[i*rri_pkg::CB +: rri_pkg::CB]);
            ax[1][i] = $signed(axis_v[i*rri_pkg::CB +: rri_pkg::CB]);
            val[i] = rri_pkg::V_W'($signed(rel1_reg[i]));
            if (sub_reg[i])
            begin
                val[i] = val[i] - $signed(rri_pkg::V_W'(prod_reg[i] >> rri_pkg::TSHIFT));
            end
            else
            begin
                val[i] = val[i] + $signed(rri_pkg::V_W'(prod_reg[i] >> rri_pkg::TSHIFT));
            end
            if (val[i] > rri_pkg::Q_LIM)
            begin
                val[i] = rri_pkg::Q_LIM;
            end
            if (val[i] < -rri_pkg::Q_LIM)
            begin
                val[i] = -rri_pkg::Q_LIM;
            end
        end
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                xd[a][i] = rri_pkg::XD_W'(xp_reg[a][2*i]) - rri_pkg::XD_W'(xp_reg[a][2*i+1]);
                xm[a][i] = xd[a][i][rri_pkg::XD_W-1] ? $unsigned(-xd[a][i])
                                                     : $unsigned(xd[a][i]);
            end
            sum4[a] = {rri_pkg::SUM_W'(sq_reg[a][0]) + rri_pkg::SUM_W'(sq_reg[a][1])
                     + rri_pkg::SUM_W'(sq_reg[a][2]), 2'b00};
        end
        hit_next = !par_reg[5]
                && (sum4[0] < rri_pkg::CMP_W'(hh_reg))
                && (sum4[1] < rri_pkg::CMP_W'(ww_reg));
    end

    always_ff @(posedge clk)
    begin
        tm_reg   <= tm_next;
        tneg_reg <= stage_in.side.neg && (tm_next != '0);
        t0_reg   <= stage_in.side.neg ? -tm_next : tm_next;
        par_reg  <= {par_reg[4:0], stage_in.side.parallel};
        rel0_reg <= stage_in.side.rel;
        dir0_reg <= stage_in.side.dir;

        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= rri_pkg::MP_W'(tm_reg)
                         * rri_pkg::MP_W'(dir0_reg[i][rri_pkg::CB-1]
                                          ? rri_pkg::CB'(-$signed(dir0_reg[i]))
                                          : dir0_reg[i]);
            sub_reg[i]  <= tneg_reg ^ dir0_reg[i][rri_pkg::CB-1];
        end
        rel1_reg <= rel0_reg;
        t1_reg   <= t0_reg;

        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= rri_pkg::Q_W'(val[i]);
        end
        t2_reg <= t1_reg;

        for (int a = 0; a < 2; a++)
        begin
            xp_reg[a][0] <= rri_pkg::XP_W'(ax[a][1]) * rri_pkg::XP_W'(q_reg[2]);
            xp_reg[a][1] <= rri_pkg::XP_W'(ax[a][2]) * rri_pkg::XP_W'(q_reg[1]);
            xp_reg[a][2] <= rri_pkg::XP_W'(ax[a][2]) * rri_pkg::XP_W'(q_reg[0]);
            xp_reg[a][3] <= rri_pkg::XP_W'(ax[a][0]) * rri_pkg::XP_W'(q_reg[2]);
            xp_reg[a][4] <= rri_pkg::XP_W'(ax[a][0]) * rri_pkg::XP_W'(q_reg[1]);
            xp_reg[a][5] <= rri_pkg::XP_W'(ax[a][1]) * rri_pkg::XP_W'(q_reg[0]);
        end
        t3_reg <= t2_reg;

        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[a][i] <= xm[a][i][rri_pkg::XD_W-1:rri_pkg::DIR_FRAC];
            end
        end
        t4_reg <= t3_reg;

        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[a][i] <= rri_pkg::SQ_W'(m_reg[a][i]) * rri_pkg::SQ_W'(m_reg[a][i]);
            end
        end
        hh_reg <= rri_pkg::WH_W'(height) * rri_pkg::WH_W'(height);
        ww_reg <= rri_pkg::WH_W'(width) * rri_pkg::WH_W'(width);
        t5_reg <= t4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done     <= 1'b0;
            hit      <= 1'b0;
            distance <= '0;
            parallel <= 1'b0;
        end
        else
        begin
            done     <= vld_reg[5];
            hit      <= hit_next;
            distance <= hit_next ? $signed(t5_reg) : '0;
            parallel <= par_reg[5];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ray_rectangle_intersect_unit.sv =====
// Top level: configuration registers and the ray and rectangle test pipeline.
//
// A ray is transferred at each rising edge with start high and busy low. busy
// stays low: the pipeline takes one ray in every cycle, with no gaps.
// The result (hit, distance, parallel) appears with done high for exactly one
// cycle; results leave in the order the rays came in. The quotient of t is
// formed one bit per register stage over 32 stages, behind three front stages
// for the plane dot products and ahead of seven back stages for the hit point
// and the axis tests. The receiver cannot hold results off, so nothing in the
// pipeline stalls. Rectangle registers are written through cfg_we, cfg_index
// and cfg_data with no wait; write them only while no ray is in flight.
// Unknown indexes are dropped. Reset clears the configuration registers, the
// valid flags and the outputs, emptying the pipeline; there is no clearing pass,
// so a ray may be started in the first cycle after reset.
// distance is signed Q16.16, saturated, and zero unless hit is set.
`timescale 1ns / 1ps
`default_nettype none
module ray_rectangle_intersect_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [rri_pkg::CB-1:0]  origin_x,
    input  wire logic signed [rri_pkg::CB-1:0]  origin_y,
    input  wire logic signed [rri_pkg::CB-1:0]  origin_z,
    input  wire logic signed [rri_pkg::CB-1:0]  dir_x,
    input  wire logic signed [rri_pkg::CB-1:0]  dir_y,
    input  wire logic signed [rri_pkg::CB-1:0]  dir_z,
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [3*rri_pkg::CB-1:0]       cfg_data,
    output logic                                done,
    output logic                                hit,
    output logic signed [rri_pkg::TB-1:0]       distance,
    output logic                                parallel
);

    logic [3*rri_pkg::CB-1:0]   centre_reg, normal_reg, axis_u_reg, axis_v_reg;
    logic [rri_pkg::CB-1:0]     width_reg, height_reg;
    logic                       take;
    rri_pkg::div_stage_t        front_st, back_st;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= '0;
            normal_reg <= '0;
            axis_u_reg <= '0;
            axis_v_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rri_pkg::CFG_CENTRE: centre_reg <= cfg_data;
                rri_pkg::CFG_NORMAL: normal_reg <= cfg_data;
                rri_pkg::CFG_AXIS_U: axis_u_reg <= cfg_data;
                rri_pkg::CFG_AXIS_V: axis_v_reg <= cfg_data;
                rri_pkg::CFG_WIDTH:  width_reg  <= cfg_data[rri_pkg::CB-1:0];
                rri_pkg::CFG_HEIGHT: height_reg <= cfg_data[rri_pkg::CB-1:0];
                default: ;
            endcase
        end
    end

    rri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take),
        .origin    ({origin_z, origin_y, origin_x}),
        .dir       ({dir_z, dir_y, dir_x}),
        .centre    (centre_reg),
        .normal    (normal_reg),
        .stage_out (front_st)
    );

    rri_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (front_st),
        .stage_out (back_st)
    );

    rri_hit u_hit (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (back_st),
        .axis_u   (axis_u_reg),
        .axis_v   (axis_v_reg),
        .width    (width_reg),
        .height   (height_reg),
        .done     (done),
        .hit      (hit),
        .distance (distance),
        .parallel (parallel)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##(rri_pkg::LATENCY) done)
        else $error("ray transfer without result at fixed latency");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, rri_pkg::LATENCY))
        else $error("result without matching ray transfer");

    a_par_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && parallel |-> !hit && distance == '0)
        else $error("parallel ray reported as hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> distance == '0)
        else $error("miss with nonzero distance");

endmodule
`default_nettype wire
